FILE: hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, constants and helpers of the Go-Back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SEQ_W      = 16;
  localparam int DATA_W     = 8;
  localparam int ENTRY_W    = DATA_W + 2;
  localparam int WIN_W      = 4;
  localparam int TMO_W      = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd5;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd200;

  // Request codes
  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_ACK    = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Register index (paddr[2])
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_SENT     = 3'd0,
    ST_REJECT   = 3'd1,
    ST_ACK_OK   = 3'd2,
    ST_ACK_IGN  = 3'd3,
    ST_TICK     = 3'd4,
    ST_RESEND   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] payload_byte;
    logic              mark_syn;
    logic              mark_fin;
    logic [SEQ_W-1:0]  ack_seq;
    logic              ack_flag;
  } req_t;

  typedef struct packed {
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [DATA_W-1:0] tx_data;
    logic              tx_syn;
    logic              tx_fin;
    logic [2:0]        status;
    logic [3:0]        outstanding;
    logic              last_of_run;
  } rsp_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_size;
    logic [TMO_W-1:0] timeout_ticks;
  } cfg_t;

  // Slot arithmetic modulo MAX_WINDOW; a < MAX_WINDOW and b <= MAX_WINDOW.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(MAX_WINDOW)) s = s - (CNT_W+1)'(MAX_WINDOW);
    return SLOT_W'(s);
  endfunction

endpackage

FILE: hdl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gbn_cfg.sv
// ----------------------------------------------------------------------------
// gbn_cfg
// APB register file: window size and timeout in ticks.
// ----------------------------------------------------------------------------
module gbn_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbn_pkg::PADDR_W-1:0] paddr,
  input  logic [gbn_pkg::PDATA_W-1:0] pwdata,
  output logic [gbn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output gbn_pkg::cfg_t               cfg_o
);

  logic [gbn_pkg::WIN_W-1:0] win_q, win_d;
  logic [gbn_pkg::TMO_W-1:0] tmo_q, tmo_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    win_d = win_q;
    tmo_d = tmo_q;
    if (wr_en) begin
      unique case (paddr[2])
        gbn_pkg::REG_WINDOW:  win_d = pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_TIMEOUT: tmo_d = pwdata[gbn_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gbn_pkg::REG_WINDOW:  prdata = gbn_pkg::PDATA_W'(win_q);
      gbn_pkg::REG_TIMEOUT: prdata = gbn_pkg::PDATA_W'(tmo_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= gbn_pkg::WINDOW_RESET;
      tmo_q <= gbn_pkg::TIMEOUT_RESET;
    end else begin
      win_q <= win_d;
      tmo_q <= tmo_d;
    end
  end

  assign cfg_o.window_size   = win_q;
  assign cfg_o.timeout_ticks = tmo_q;

endmodule

FILE: hdl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window bookkeeping, request handling, resend sequencer and result register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gbn_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gbn_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gbn_pkg::rsp_t                out_data_o,
  output logic                         ram_we_o,
  output logic [gbn_pkg::SLOT_W-1:0]   ram_waddr_o,
  output logic [gbn_pkg::ENTRY_W-1:0]  ram_wdata_o,
  output logic                         ram_re_o,
  output logic [gbn_pkg::SLOT_W-1:0]   ram_raddr_o,
  input  logic [gbn_pkg::ENTRY_W-1:0]  ram_rdata_i
);

  gbn_pkg::state_e state_q, state_d;

  logic [gbn_pkg::SLOT_W-1:0] head_q, head_d;
  logic [gbn_pkg::CNT_W-1:0]  count_q, count_d;
  logic [gbn_pkg::SEQ_W-1:0]  base_q, base_d;
  logic [gbn_pkg::TMO_W-1:0]  elapsed_q, elapsed_d;
  logic [gbn_pkg::SLOT_W-1:0] idx_q, idx_d;
  gbn_pkg::rsp_t              out_q, out_d;
  logic                       out_vld_q, out_vld_d;

  logic                       out_free;
  logic                       in_acc;
  logic [gbn_pkg::CNT_W-1:0]  win_lim;
  logic [gbn_pkg::TMO_W-1:0]  tmo_lim;
  logic [gbn_pkg::TMO_W-1:0]  elapsed_inc;
  logic                       timeout;
  logic                       last;
  logic [gbn_pkg::CNT_W-1:0]  idx_next;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != gbn_pkg::S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (32'(cfg_i.window_size) > gbn_pkg::MAX_WINDOW) begin
      win_lim = gbn_pkg::CNT_W'(gbn_pkg::MAX_WINDOW);
    end else if (cfg_i.window_size == '0) begin
      win_lim = gbn_pkg::CNT_W'(1);
    end else begin
      win_lim = gbn_pkg::CNT_W'(cfg_i.window_size);
    end
  end

  assign tmo_lim     = (cfg_i.timeout_ticks == '0) ? gbn_pkg::TMO_W'(1) : cfg_i.timeout_ticks;
  assign elapsed_inc = elapsed_q + gbn_pkg::TMO_W'(1);
  assign timeout     = (in_data_i.req_type == gbn_pkg::REQ_TICK) && (count_q != '0)
                       && (elapsed_inc >= tmo_lim);
  assign idx_next    = gbn_pkg::CNT_W'(idx_q) + gbn_pkg::CNT_W'(1);
  assign last        = (idx_next == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbn_pkg::S_IDLE: begin
        if (in_acc && timeout) state_d = gbn_pkg::S_READ;
      end
      gbn_pkg::S_READ: state_d = gbn_pkg::S_LOAD;
      gbn_pkg::S_LOAD: begin
        if (out_free && last) state_d = gbn_pkg::S_IDLE;
      end
      default: state_d = gbn_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory port and result register
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    base_d      = base_q;
    elapsed_d   = elapsed_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    ram_we_o    = 1'b0;
    ram_waddr_o = gbn_pkg::slot_add(head_q, count_q);
    ram_wdata_o = {in_data_i.mark_fin, in_data_i.mark_syn, in_data_i.payload_byte};
    ram_re_o    = 1'b0;
    ram_raddr_o = gbn_pkg::slot_add(head_q, gbn_pkg::CNT_W'(idx_q));

    unique case (state_q)
      gbn_pkg::S_IDLE: begin
        if (in_acc) begin
          out_d             = '0;
          out_d.last_of_run = 1'b1;
          out_d.outstanding = 4'(count_q);
          case (in_data_i.req_type)
            gbn_pkg::REQ_SUBMIT: begin
              out_vld_d = 1'b1;
              if (count_q < win_lim) begin
                ram_we_o          = 1'b1;
                count_d           = count_q + gbn_pkg::CNT_W'(1);
                if (count_q == '0) elapsed_d = '0;
                out_d.tx_valid    = 1'b1;
                out_d.tx_seq      = base_q + gbn_pkg::SEQ_W'(count_q);
                out_d.tx_data     = in_data_i.payload_byte;
                out_d.tx_syn      = in_data_i.mark_syn;
                out_d.tx_fin      = in_data_i.mark_fin;
                out_d.status      = gbn_pkg::ST_SENT;
                out_d.outstanding = 4'(count_d);
              end else begin
                out_d.status = gbn_pkg::ST_REJECT;
              end
            end
            gbn_pkg::REQ_ACK: begin
              out_vld_d = 1'b1;
              if (count_q != '0 && in_data_i.ack_seq == base_q && in_data_i.ack_flag) begin
                head_d            = gbn_pkg::slot_add(head_q, gbn_pkg::CNT_W'(1));
                base_d            = base_q + gbn_pkg::SEQ_W'(1);
                count_d           = count_q - gbn_pkg::CNT_W'(1);
                elapsed_d         = '0;
                out_d.status      = gbn_pkg::ST_ACK_OK;
                out_d.outstanding = 4'(count_d);
              end else begin
                out_d.status = gbn_pkg::ST_ACK_IGN;
              end
            end
            gbn_pkg::REQ_TICK: begin
              if (timeout) begin
                // start the resend run, oldest first
                elapsed_d = '0;
                idx_d     = '0;
                out_d     = out_q;
              end else begin
                if (count_q != '0) elapsed_d = elapsed_inc;
                out_vld_d    = 1'b1;
                out_d.status = gbn_pkg::ST_TICK;
              end
            end
            default: begin
              out_d = out_q;
            end
          endcase
        end
      end
      gbn_pkg::S_READ: begin
        ram_re_o = 1'b1;
      end
      gbn_pkg::S_LOAD: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.tx_valid    = 1'b1;
          out_d.tx_seq      = base_q + gbn_pkg::SEQ_W'(idx_q);
          out_d.tx_data     = ram_rdata_i[gbn_pkg::DATA_W-1:0];
          out_d.tx_syn      = ram_rdata_i[gbn_pkg::DATA_W];
          out_d.tx_fin      = ram_rdata_i[gbn_pkg::DATA_W+1];
          out_d.status      = gbn_pkg::ST_RESEND;
          out_d.outstanding = 4'(count_q);
          out_d.last_of_run = last;
          if (!last) begin
            // fetch the next entry while this one goes out
            idx_d       = gbn_pkg::SLOT_W'(idx_next);
            ram_re_o    = 1'b1;
            ram_raddr_o = gbn_pkg::slot_add(head_q, idx_next);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gbn_pkg::S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      base_q    <= '0;
      elapsed_q <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      base_q    <= base_d;
      elapsed_q <= elapsed_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/go_back_n_sender_window_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N sender window with the outstanding packets kept in a small RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_*): submit, ack or tick items, taken when in_valid_i
//   is high and in_stall_o is low. Result channel (out_*): one result per
//   submit, ack or tick, or a run of results on a timeout, the last of which
//   carries last_of_run. Request type three is taken and gives no result.
//   A result is in the output register in the cycle after its item is taken;
//   the first packet of a resend run passes the window RAM read (S_READ) and
//   the load state (S_LOAD) on its way there. Submits, acks and plain ticks
//   never hold the request side themselves. A timeout holds it while all
//   outstanding packets are resent: the first window RAM read, then one
//   resent packet per cycle unless the result channel stalls (one read port).
//   The receiver stalling the result channel holds the output register and
//   stalls the request side and the resend run with it.
//   Reset clears the window (empty, base sequence zero, timer zero) and loads
//   window_size 5 and timeout_ticks 200. The APB port writes the registers;
//   write them only while the block is idle.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbn_pkg::req_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbn_pkg::rsp_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbn_pkg::PADDR_W-1:0] paddr,
  input  logic [gbn_pkg::PDATA_W-1:0] pwdata,
  output logic [gbn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  gbn_pkg::cfg_t                cfg;
  logic                         ram_we;
  logic [gbn_pkg::SLOT_W-1:0]   ram_waddr;
  logic [gbn_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [gbn_pkg::SLOT_W-1:0]   ram_raddr;
  logic [gbn_pkg::ENTRY_W-1:0]  ram_rdata;

  gbn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gbn_ram #(
    .WIDTH (gbn_pkg::ENTRY_W),
    .DEPTH (gbn_pkg::MAX_WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Window writes come only from an accepted submit.
  a_write_on_submit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_valid_i && !in_stall_o && in_data_i.req_type == gbn_pkg::REQ_SUBMIT))
    else $error("window write without an accepted submit");

  // A resend read never overlaps a window write.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("window read and write in the same cycle");

  // A resend run has no gaps once its first packet is shown.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_of_run) |=> out_valid_o)
    else $error("resend run broken before its last packet");

endmodule

FILE: verif/gbn_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbn_window_checker
// Watches the request, result and APB channels of the Go-Back-N sender
// window, keeps its own copy of the window state and registers, predicts the
// results of every accepted item and compares them, field by field, in order.
// ----------------------------------------------------------------------------
module gbn_window_checker
  import gbn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  req_t               in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  rsp_t               out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output int                 fail_count_o,
  output int                 due_count_o
);

  logic [ENTRY_W-1:0] win_entry [MAX_WINDOW];
  logic [SLOT_W-1:0]  oldest_slot;
  logic [CNT_W-1:0]   in_flight;
  logic [SEQ_W-1:0]   base_sn;
  logic [TMO_W-1:0]   tick_count;
  logic [WIN_W-1:0]   win_size;
  logic [TMO_W-1:0]   timeout_len;
  rsp_t               tx_due_q [$];
  int                 mismatches;
  int                 due_count;

  assign fail_count_o = mismatches;
  assign due_count_o  = due_count;

  function automatic logic [CNT_W-1:0] window_cap();
    if (win_size == '0) return CNT_W'(1);
    if (win_size > MAX_WINDOW) return CNT_W'(MAX_WINDOW);
    return CNT_W'(win_size);
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Append one expected result behind the ones already due.
  task automatic queue_result(input rsp_t r);
    tx_due_q.insert(tx_due_q.size(), r);
  endtask

  // Advance the window model by one item and queue the results it causes.
  task automatic predict_window(input req_t item);
    rsp_t               r;
    logic [SLOT_W-1:0]  slot;
    logic [TMO_W-1:0]   tmo_lim;
    logic [ENTRY_W-1:0] entry;
    int                 n;
    r = '0;
    r.last_of_run = 1'b1;
    case (item.req_type)
      REQ_SUBMIT: begin
        if (in_flight < window_cap()) begin
          slot = SLOT_W'((oldest_slot + in_flight) % MAX_WINDOW);
          win_entry[slot] = {item.mark_fin, item.mark_syn, item.payload_byte};
          if (in_flight == '0) tick_count = '0;
          r.tx_valid = 1'b1;
          r.tx_seq   = base_sn + SEQ_W'(in_flight);
          r.tx_data  = item.payload_byte;
          r.tx_syn   = item.mark_syn;
          r.tx_fin   = item.mark_fin;
          r.status   = ST_SENT;
          in_flight++;
        end else begin
          r.status = ST_REJECT;
        end
        r.outstanding = 4'(in_flight);
        queue_result(r);
      end
      REQ_ACK: begin
        if (in_flight != '0 && item.ack_seq == base_sn && item.ack_flag) begin
          oldest_slot = SLOT_W'((oldest_slot + 1) % MAX_WINDOW);
          base_sn++;
          in_flight--;
          tick_count = '0;
          r.status = ST_ACK_OK;
        end else begin
          r.status = ST_ACK_IGN;
        end
        r.outstanding = 4'(in_flight);
        queue_result(r);
      end
      REQ_TICK: begin
        tmo_lim = (timeout_len == '0) ? TMO_W'(1) : timeout_len;
        r.status = ST_TICK;
        if (in_flight != '0) begin
          tick_count++;
          if (tick_count >= tmo_lim) begin
            tick_count = '0;
            r.status = ST_RESEND;
          end
        end
        if (r.status == ST_RESEND) begin
          // Resend the whole window, oldest first.
          n = in_flight;
          for (int k = 0; k < n; k++) begin
            slot          = SLOT_W'((oldest_slot + k) % MAX_WINDOW);
            entry         = win_entry[slot];
            r.tx_valid    = 1'b1;
            r.tx_seq      = base_sn + SEQ_W'(k);
            r.tx_data     = entry[DATA_W-1:0];
            r.tx_syn      = entry[DATA_W];
            r.tx_fin      = entry[DATA_W+1];
            r.outstanding = 4'(in_flight);
            r.last_of_run = (k == n - 1);
            queue_result(r);
          end
        end else begin
          r.outstanding = 4'(in_flight);
          queue_result(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      oldest_slot = '0;
      in_flight   = '0;
      base_sn     = '0;
      tick_count  = '0;
      win_size    = WINDOW_RESET;
      timeout_len = TIMEOUT_RESET;
      mismatches  = 0;
      tx_due_q.delete();
      due_count   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (tx_due_q.size() == 0) begin
          $display("%0t: result expected none, got %p", $time, out_data_i);
          mismatches++;
        end else begin
          want = tx_due_q.pop_front();
          compare_field("tx_valid", want.tx_valid, out_data_i.tx_valid);
          compare_field("tx_seq", want.tx_seq, out_data_i.tx_seq);
          compare_field("tx_data", want.tx_data, out_data_i.tx_data);
          compare_field("tx_syn", want.tx_syn, out_data_i.tx_syn);
          compare_field("tx_fin", want.tx_fin, out_data_i.tx_fin);
          compare_field("status", want.status, out_data_i.status);
          compare_field("outstanding", want.outstanding, out_data_i.outstanding);
          compare_field("last_of_run", want.last_of_run, out_data_i.last_of_run);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_WINDOW) win_size = pwdata_i[WIN_W-1:0];
        else timeout_len = pwdata_i[TMO_W-1:0];
      end
      if (in_valid_i && !in_stall_i) predict_window(in_data_i);
      due_count = tx_due_q.size();
    end
  end

endmodule

FILE: verif/go_back_n_sender_window_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit_test
// Drives submits, acks and ticks into the Go-Back-N sender window under
// several window and timeout settings and idle/stall patterns; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit_test;
  import gbn_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES   = MAX_WINDOW + 4;
  localparam int         HOLD_CYCLES     = 120;
  localparam int         NUM_PHASES      = 6;
  localparam int         ITEMS_PER_PHASE = 30;
  localparam int         PRESSURE_PHASE  = 4;

  int unsigned phase_win   [NUM_PHASES] = '{8, 4, 1, 15, 8, 5};
  int unsigned phase_tmo   [NUM_PHASES] = '{3, 65535, 6, 1, 4, 200};
  int unsigned phase_idle  [NUM_PHASES] = '{0, 68, 0, 27, 0, 40};
  int unsigned phase_stall [NUM_PHASES] = '{0, 0, 68, 27, 0, 40};

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  req_t               in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsp_t               out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 fail_count;
  int                 results_due;
  int unsigned        idle_pct   = 0;
  int unsigned        stall_pct  = 0;
  int                 hold_asked = 0;
  int                 hold_done  = 0;
  logic [SEQ_W-1:0]   acks_seen  = '0;

  go_back_n_sender_window_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  gbn_window_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .due_count_o  (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Track accepted acks so most generated acks hit the oldest packet.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && out_data_o.status == ST_ACK_OK) begin
      acks_seen <= acks_seen + 1'b1;
    end
  end

  // Receiver: random stall, or a long hold-off when one is asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] data,
                                    input logic syn, input logic fin,
                                    input logic [15:0] seq, input logic flag);
    req_t r;
    r.req_type     = kind;
    r.payload_byte = data;
    r.mark_syn     = syn;
    r.mark_fin     = fin;
    r.ack_seq      = seq;
    r.ack_flag     = flag;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = make_req(REQ_SUBMIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.req_type = REQ_SUBMIT;
    end else if (pick < 75) begin
      r.req_type = REQ_ACK;
      // Mostly well-formed acks; the rest carry a random sequence or flag.
      if (pick < 68) begin
        r.ack_flag = 1'b1;
        r.ack_seq  = acks_seen + SEQ_W'($urandom_range(9) == 0);
      end
    end else if (pick < 97) begin
      r.req_type = REQ_TICK;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic offer(input req_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= req_t'($bits(req_t)'($urandom));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result has come and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty window: idle tick, stray ack, unused request type.
    offer(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    offer(make_req(REQ_ACK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1));
    offer(make_req(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1));
    settle();

    // Zero window and zero timeout act as one.
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    offer(make_req(REQ_SUBMIT, 8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0));
    offer(make_req(REQ_SUBMIT, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    offer(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    offer(make_req(REQ_ACK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    offer(make_req(REQ_ACK, 8'h00, 1'b0, 1'b0, 16'hFFFF, 1'b1));
    offer(make_req(REQ_ACK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1));
    settle();

    // Oversized window clamps to the full store; fill it, overflow, resend all.
    write_reg(REG_WINDOW, 32'd15);
    write_reg(REG_TIMEOUT, 32'd2);
    for (int i = 0; i < MAX_WINDOW + 1; i++) begin
      offer(make_req(REQ_SUBMIT, i[0] ? 8'hA5 : 8'h5A, i[0], i[1], 16'h0000, 1'b0));
    end
    offer(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    offer(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    settle();

    // Shrink the window below what is outstanding.
    write_reg(REG_WINDOW, 32'd2);
    offer(make_req(REQ_SUBMIT, 8'h3C, 1'b0, 1'b1, 16'h0000, 1'b0));
    offer(make_req(REQ_ACK, 8'h00, 1'b0, 1'b0, 16'h0001, 1'b1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_WINDOW, phase_win[p]);
      write_reg(REG_TIMEOUT, phase_tmo[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == PRESSURE_PHASE && n == 4) hold_asked++;
        if (p == PRESSURE_PHASE && n == 20) settle();
        offer(random_request());
      end
    end
    settle();

    if (fail_count == 0) begin
      $display("go_back_n_sender_window_unit regression: pass");
    end else begin
      $display("go_back_n_sender_window_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("go_back_n_sender_window_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/gbn_cfg.sv
hdl/gbn_ctrl.sv
hdl/go_back_n_sender_window_unit.sv
verif/gbn_window_checker.sv
verif/go_back_n_sender_window_unit_test.sv
